>>> rtl/bhdm_pkg.sv
// Package: types, constants and state codes of the block hash delta matcher.
`default_nettype none

package bhdm_pkg;

    localparam int unsigned TABLE_ENTRIES_DEF = 256;

    localparam int unsigned HASH_W   = 30;
    localparam int unsigned OFFS_W   = 32;
    localparam int unsigned LEN_W    = 17;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned RED_W    = HASH_W + BYTE_W;
    localparam int unsigned RED_STEPS = 9;
    localparam int unsigned STEP_W   = 4;

    localparam logic [HASH_W-1:0] HASH_MOD   = 30'd1000000007;
    localparam logic [LEN_W-1:0]  CHUNK_RESET = 17'd16384;
    localparam logic [LEN_W-1:0]  CHUNK_MAX   = 17'd65536;
    localparam logic [LEN_W-1:0]  CHUNK_MIN   = 17'd1;

    localparam logic MODE_BASE = 1'b0;
    localparam logic MODE_NEW  = 1'b1;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_COPY   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HASH,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_EMIT
    } bhdm_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } bhdm_red_stat_t;

    typedef struct packed {
        logic [HASH_W-1:0] hash;
        logic [OFFS_W-1:0] offset;
        logic [LEN_W-1:0]  length;
    } bhdm_entry_t;

endpackage

`default_nettype wire

>>> rtl/bhdm_modred.sv
// Iterative modulo reduction unit: one shifted compare and subtract per cycle.
`default_nettype none

module bhdm_modred
    import bhdm_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                start,
    input  wire logic [RED_W-1:0]    value,
    output bhdm_red_stat_t           stat,
    output logic [HASH_W-1:0]        result
);

    localparam logic [RED_W-1:0] DIV_INIT =
        RED_W'({8'd0, HASH_MOD} << (RED_STEPS - 1));

    logic [RED_W-1:0]  rem_reg,  rem_next;
    logic [RED_W-1:0]  div_reg,  div_next;
    logic [STEP_W-1:0] cnt_reg,  cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    always_comb begin
        rem_next  = rem_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = value;
            div_next  = DIV_INIT;
            cnt_next  = STEP_W'(RED_STEPS - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (rem_reg >= div_reg) begin
                rem_next = rem_reg - div_reg;
            end
            div_next = div_reg >> 1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        div_reg <= div_next;
        cnt_reg <= cnt_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = rem_reg[HASH_W-1:0];

endmodule

`default_nettype wire

>>> rtl/bhdm_table.sv
// Chunk table memory: one write port, one registered read port.
`default_nettype none

module bhdm_table
    import bhdm_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             wr_en,
    input  wire logic [$clog2(TABLE_ENTRIES)-1:0] wr_addr,
    input  wire bhdm_entry_t                      wr_data,
    input  wire logic                             rd_en,
    input  wire logic [$clog2(TABLE_ENTRIES)-1:0] rd_addr,
    output bhdm_entry_t                           rd_data
);

    bhdm_entry_t mem [TABLE_ENTRIES];
    bhdm_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> rtl/block_hash_delta_matcher.sv
// Top level: byte sequencer, chunk hashing, table search and result register.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  s_      | s_valid s_ready s_mode s_data_byte      | request in
//          | s_stream_end                            |
//  m_      | m_valid m_ready m_command               | result out
//          | m_source_offset m_chunk_length          |
//          | m_table_overflowed                      |
//  cfg_    | cfg_valid cfg_ready cfg_data            | chunk size write
//
// Each byte goes through accept, nine compare and subtract steps of the single
// modulo unit, and a closing step. A closing chunk then scans the table, a read
// and a compare state per stored entry, through the single memory read port.
// Reset is synchronous; the table needs no clearing pass (fill count).
// A result waiting in the output register holds the next result, and input with it.
`default_nettype none

module block_hash_delta_matcher
    import bhdm_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic                 s_mode,
    input  wire logic [BYTE_W-1:0]    s_data_byte,
    input  wire logic                 s_stream_end,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic                      m_command,
    output logic [OFFS_W-1:0]         m_source_offset,
    output logic [LEN_W-1:0]          m_chunk_length,
    output logic                      m_table_overflowed,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [LEN_W-1:0]     cfg_data
);

    localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
    localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] USED_MAX = CNT_W'(TABLE_ENTRIES);

    bhdm_state_t       state_reg, state_next;
    logic              mode_reg, mode_next;
    logic              last_reg, last_next;
    logic [HASH_W-1:0] hash_reg, hash_next;
    logic [LEN_W-1:0]  bytes_reg, bytes_next;
    logic [OFFS_W-1:0] base_off_reg, base_off_next;
    logic [CNT_W-1:0]  used_reg, used_next;
    logic              ovf_reg, ovf_next;
    logic [LEN_W-1:0]  chunk_size_reg, chunk_size_next;
    logic [HASH_W-1:0] cl_hash_reg, cl_hash_next;
    logic [LEN_W-1:0]  cl_len_reg, cl_len_next;
    logic [CNT_W-1:0]  scan_reg, scan_next;
    logic              res_cmd_reg, res_cmd_next;
    logic [OFFS_W-1:0] res_off_reg, res_off_next;
    logic [LEN_W-1:0]  res_len_reg, res_len_next;
    logic              m_valid_reg, m_valid_next;
    logic              m_cmd_reg, m_cmd_next;
    logic [OFFS_W-1:0] m_off_reg, m_off_next;
    logic [LEN_W-1:0]  m_len_reg, m_len_next;
    logic              m_ovf_reg, m_ovf_next;

    logic              red_start;
    logic [RED_W-1:0]  red_value;
    logic [HASH_W-1:0] red_result;
    bhdm_red_stat_t    red_stat;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    bhdm_entry_t       wr_data;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    bhdm_entry_t       rd_data;

    logic [LEN_W-1:0]  eff_size;
    logic              in_accept;

    bhdm_modred u_modred (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (red_start),
        .value   (red_value),
        .stat    (red_stat),
        .result  (red_result)
    );

    bhdm_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign in_accept = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    always_comb begin
        if (chunk_size_reg == '0) begin
            eff_size = CHUNK_MIN;
        end else if (chunk_size_reg > CHUNK_MAX) begin
            eff_size = CHUNK_MAX;
        end else begin
            eff_size = chunk_size_reg;
        end
    end

    assign red_value = {hash_reg, {BYTE_W{1'b0}}} + {{BYTE_W{1'b0}}, hash_reg}
                     + {{HASH_W{1'b0}}, s_data_byte};

    always_comb begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        last_next       = last_reg;
        hash_next       = hash_reg;
        bytes_next      = bytes_reg;
        base_off_next   = base_off_reg;
        used_next       = used_reg;
        ovf_next        = ovf_reg;
        chunk_size_next = chunk_size_reg;
        cl_hash_next    = cl_hash_reg;
        cl_len_next     = cl_len_reg;
        scan_next       = scan_reg;
        res_cmd_next    = res_cmd_reg;
        res_off_next    = res_off_reg;
        res_len_next    = res_len_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_cmd_next      = m_cmd_reg;
        m_off_next      = m_off_reg;
        m_len_next      = m_len_reg;
        m_ovf_next      = m_ovf_reg;
        red_start       = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = scan_reg[IDX_W-1:0];
        wr_data.hash    = cl_hash_reg;
        wr_data.offset  = base_off_reg;
        wr_data.length  = cl_len_reg;
        rd_en           = 1'b0;
        rd_addr         = scan_reg[IDX_W-1:0];

        if (cfg_valid) begin
            chunk_size_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    mode_next  = s_mode;
                    last_next  = s_stream_end;
                    red_start  = 1'b1;
                    if (bytes_reg < CHUNK_MAX) begin
                        bytes_next = bytes_reg + 1'b1;
                    end
                    state_next = ST_HASH;
                end
            end
            ST_HASH: begin
                if (red_stat.done) begin
                    if (last_reg || (bytes_reg >= eff_size)) begin
                        cl_hash_next = red_result;
                        cl_len_next  = bytes_reg;
                        hash_next    = '0;
                        bytes_next   = '0;
                        scan_next    = '0;
                        state_next   = ST_SRCH_RD;
                    end else begin
                        hash_next  = red_result;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SRCH_RD: begin
                if (scan_reg == used_reg) begin
                    if (mode_reg == MODE_BASE) begin
                        if (used_reg >= USED_MAX) begin
                            ovf_next = 1'b1;
                        end else begin
                            wr_en     = 1'b1;
                            wr_addr   = used_reg[IDX_W-1:0];
                            used_next = used_reg + 1'b1;
                        end
                        base_off_next = base_off_reg + {{(OFFS_W-LEN_W){1'b0}}, cl_len_reg};
                        state_next    = ST_IDLE;
                    end else begin
                        res_cmd_next = CMD_INSERT;
                        res_off_next = '0;
                        res_len_next = cl_len_reg;
                        state_next   = ST_EMIT;
                    end
                end else begin
                    rd_en      = 1'b1;
                    state_next = ST_SRCH_CMP;
                end
            end
            ST_SRCH_CMP: begin
                if (rd_data.hash == cl_hash_reg) begin
                    if (mode_reg == MODE_BASE) begin
                        wr_en         = 1'b1;
                        base_off_next = base_off_reg + {{(OFFS_W-LEN_W){1'b0}}, cl_len_reg};
                        state_next    = ST_IDLE;
                    end else begin
                        res_cmd_next = CMD_COPY;
                        res_off_next = rd_data.offset;
                        res_len_next = rd_data.length;
                        state_next   = ST_EMIT;
                    end
                end else begin
                    scan_next  = scan_reg + 1'b1;
                    state_next = ST_SRCH_RD;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_cmd_next   = res_cmd_reg;
                    m_off_next   = res_off_reg;
                    m_len_next   = res_len_reg;
                    m_ovf_next   = ovf_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            hash_reg       <= '0;
            bytes_reg      <= '0;
            base_off_reg   <= '0;
            used_reg       <= '0;
            ovf_reg        <= 1'b0;
            chunk_size_reg <= CHUNK_RESET;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            hash_reg       <= hash_next;
            bytes_reg      <= bytes_next;
            base_off_reg   <= base_off_next;
            used_reg       <= used_next;
            ovf_reg        <= ovf_next;
            chunk_size_reg <= chunk_size_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg    <= mode_next;
        last_reg    <= last_next;
        cl_hash_reg <= cl_hash_next;
        cl_len_reg  <= cl_len_next;
        scan_reg    <= scan_next;
        res_cmd_reg <= res_cmd_next;
        res_off_reg <= res_off_next;
        res_len_reg <= res_len_next;
        m_cmd_reg   <= m_cmd_next;
        m_off_reg   <= m_off_next;
        m_len_reg   <= m_len_next;
        m_ovf_reg   <= m_ovf_next;
    end

    assign m_valid            = m_valid_reg;
    assign m_command          = m_cmd_reg;
    assign m_source_offset    = m_off_reg;
    assign m_chunk_length     = m_len_reg;
    assign m_table_overflowed = m_ovf_reg;

    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= USED_MAX)
        else $error("table fill count beyond table size");

    a_ovf_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        !$fell(ovf_reg))
        else $error("overflow flag cleared outside reset");

    a_bytes_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        bytes_reg <= CHUNK_MAX)
        else $error("chunk byte count beyond maximum");

    a_red_done_hash: assert property (@(posedge aclk) disable iff (!aresetn)
        (red_stat.busy || red_stat.done) |-> (state_reg == ST_HASH))
        else $error("modulo unit active outside hashing");

    a_emit_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_EMIT))
        else $error("result raised without emit step");

endmodule

`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 1ps
// Testbench: directed and random base/new byte streams with a command scoreboard.
module tb;
    import bhdm_pkg::*;

    localparam int unsigned HASH_MUL      = 257;
    localparam int          SETTLE_CYCLES = 600;
    localparam int          QUIET_LIMIT   = 20000;
    localparam int          MAX_PRINTS    = 30;

    typedef struct {
        logic              command;
        logic [OFFS_W-1:0] offset;
        logic [LEN_W-1:0]  length;
        logic              overflowed;
    } delta_cmd_t;

    class delta_cmd_tracker;
        logic [LEN_W-1:0]  chunk_reg;
        logic [HASH_W-1:0] run_hash;
        int unsigned       fill;
        logic [OFFS_W-1:0] base_pos;
        logic [HASH_W-1:0] tbl_hash   [TABLE_ENTRIES_DEF];
        logic [OFFS_W-1:0] tbl_offset [TABLE_ENTRIES_DEF];
        logic [LEN_W-1:0]  tbl_length [TABLE_ENTRIES_DEF];
        int unsigned       used;
        logic              overflowed;
        delta_cmd_t        pending_cmds [$];
        int                mismatches;
        int                checked;
        int                copies;
        int                inserts;

        function new();
            chunk_reg  = CHUNK_RESET;
            run_hash   = '0;
            fill       = 0;
            base_pos   = '0;
            used       = 0;
            overflowed = 1'b0;
            mismatches = 0;
            checked    = 0;
            copies     = 0;
            inserts    = 0;
        endfunction

        function void set_chunk_size(input logic [LEN_W-1:0] v);
            chunk_reg = v;
        endfunction

        function int outstanding();
            return pending_cmds.size();
        endfunction

        function int lookup(input logic [HASH_W-1:0] h);
            for (int i = 0; i < used; i++) begin
                if (tbl_hash[i] == h) begin
                    return i;
                end
            end
            return -1;
        endfunction

        function void note_byte(input logic mode, input logic [BYTE_W-1:0] b, input logic last);
            longint unsigned acc;
            int unsigned     limit;
            int              slot;
            delta_cmd_t      cmd;
            acc = run_hash;
            acc = (acc * HASH_MUL + b) % HASH_MOD;
            run_hash = acc[HASH_W-1:0];
            if (fill < CHUNK_MAX) begin
                fill++;
            end
            limit = (chunk_reg == 0) ? 1 : (chunk_reg > CHUNK_MAX) ? CHUNK_MAX : chunk_reg;
            if (!last && fill < limit) begin
                return;
            end
            slot = lookup(run_hash);
            if (mode == MODE_BASE) begin
                if (slot < 0 && used < TABLE_ENTRIES_DEF) begin
                    slot = used;
                    used++;
                end
                if (slot < 0) begin
                    overflowed = 1'b1;
                end else begin
                    tbl_hash[slot]   = run_hash;
                    tbl_offset[slot] = base_pos;
                    tbl_length[slot] = LEN_W'(fill);
                end
                base_pos = base_pos + OFFS_W'(fill);
            end else begin
                if (slot >= 0) begin
                    cmd.command = CMD_COPY;
                    cmd.offset  = tbl_offset[slot];
                    cmd.length  = tbl_length[slot];
                    copies++;
                end else begin
                    cmd.command = CMD_INSERT;
                    cmd.offset  = '0;
                    cmd.length  = LEN_W'(fill);
                    inserts++;
                end
                cmd.overflowed = overflowed;
                pending_cmds.push_back(cmd);
            end
            run_hash = '0;
            fill     = 0;
        endfunction

        task report_mismatch(input string field, input logic [OFFS_W-1:0] got,
                             input logic [OFFS_W-1:0] want);
            mismatches++;
            if (mismatches <= MAX_PRINTS) begin
                $display("%0t: mismatch on %s: got %0h, expected %0h", $time, field, got, want);
            end
        endtask

        task check_cmd(input logic command, input logic [OFFS_W-1:0] offset,
                       input logic [LEN_W-1:0] length, input logic ovf);
            delta_cmd_t want;
            checked++;
            if (pending_cmds.size() == 0) begin
                report_mismatch("command with none outstanding", OFFS_W'(command), '0);
                return;
            end
            want = pending_cmds.pop_front();
            if (command !== want.command) begin
                report_mismatch("command", OFFS_W'(command), OFFS_W'(want.command));
            end
            if (offset !== want.offset) begin
                report_mismatch("source_offset", offset, want.offset);
            end
            if (length !== want.length) begin
                report_mismatch("chunk_length", OFFS_W'(length), OFFS_W'(want.length));
            end
            if (ovf !== want.overflowed) begin
                report_mismatch("table_overflowed", OFFS_W'(ovf), OFFS_W'(want.overflowed));
            end
        endtask
    endclass

    logic                 aclk         = 1'b0;
    logic                 aresetn      = 1'b0;
    logic                 s_valid      = 1'b0;
    logic                 s_mode       = 1'b0;
    logic [BYTE_W-1:0]    s_data_byte  = '0;
    logic                 s_stream_end = 1'b0;
    logic                 m_ready      = 1'b0;
    logic                 cfg_valid    = 1'b0;
    logic [LEN_W-1:0]     cfg_data     = '0;
    logic                 s_ready;
    logic                 m_valid;
    logic                 m_command;
    logic [OFFS_W-1:0]    m_source_offset;
    logic [LEN_W-1:0]     m_chunk_length;
    logic                 m_table_overflowed;
    logic                 cfg_ready;

    int                   s_idle_pct = 25;
    int                   m_idle_pct = 84;
    int                   bytes_sent = 0;
    int                   quiet      = 0;
    delta_cmd_tracker     tracker;

    block_hash_delta_matcher #(
        .TABLE_ENTRIES(TABLE_ENTRIES_DEF)
    ) dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_mode            (s_mode),
        .s_data_byte       (s_data_byte),
        .s_stream_end      (s_stream_end),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_command         (m_command),
        .m_source_offset   (m_source_offset),
        .m_chunk_length    (m_chunk_length),
        .m_table_overflowed(m_table_overflowed),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= m_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                tracker.check_cmd(m_command, m_source_offset, m_chunk_length,
                                  m_table_overflowed);
            end
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet = quiet + 1;
            end
            if (quiet >= QUIET_LIMIT) begin
                $display("FAIL block_hash_delta_matcher");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic mode, input logic [BYTE_W-1:0] b, input logic last);
        while ($urandom_range(99) < s_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_mode       <= mode;
        s_data_byte  <= b;
        s_stream_end <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tracker.note_byte(mode, b, last);
        bytes_sent++;
    endtask

    // hold the sender until every command is back, then let the block settle
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (tracker.outstanding() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_chunk_size(input logic [LEN_W-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        tracker.set_chunk_size(v);
    endtask

    function automatic logic [LEN_W-1:0] pick_chunk_size();
        int pick;
        pick = $urandom_range(19);
        if (pick <= 12) begin
            return LEN_W'($urandom_range(1, 8));
        end else if (pick <= 15) begin
            return LEN_W'($urandom_range(9, 32));
        end else if (pick == 16) begin
            return '0;
        end else if (pick == 17) begin
            return CHUNK_MAX;
        end else if (pick == 18) begin
            return '1;
        end
        return LEN_W'($urandom_range(33, 131071));
    endfunction

    // base stream of chunks, then a new stream of copied, altered and fresh chunks
    task automatic run_session(input logic [LEN_W-1:0] csize);
        logic [BYTE_W-1:0] base_bytes [$];
        int                chunk_at [$];
        int                chunk_len [$];
        int                unit;
        int                n_chunks;
        int                segs;
        int                k;
        int                seg_len;
        int                pick;
        int                flip_at;
        logic              whole;
        logic              seg_end;
        logic [BYTE_W-1:0] b;
        write_chunk_size(csize);
        whole = (csize > 32);
        if (whole) begin
            unit     = $urandom_range(3, 24);
            n_chunks = 1;
        end else begin
            unit     = (csize == 0) ? 1 : csize;
            n_chunks = $urandom_range(2, (unit <= 8) ? 10 : 3);
        end
        for (int c = 0; c < n_chunks; c++) begin
            chunk_at.push_back(base_bytes.size());
            seg_len = unit;
            if (c == n_chunks - 1 && !whole && $urandom_range(3) == 0) begin
                seg_len = $urandom_range(1, unit);
            end
            chunk_len.push_back(seg_len);
            repeat (seg_len) base_bytes.push_back(BYTE_W'($urandom_range(255)));
        end
        if ($urandom_range(5) == 0) begin
            send_byte(1'($urandom_range(1)), BYTE_W'($urandom_range(255)),
                      ($urandom_range(3) == 0));
        end
        for (int i = 0; i < base_bytes.size(); i++) begin
            send_byte(MODE_BASE, base_bytes[i], (i == base_bytes.size() - 1));
        end
        segs = $urandom_range(2, 12);
        for (int s = 0; s < segs; s++) begin
            if ($urandom_range(7) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    send_byte(1'($urandom_range(1)), BYTE_W'($urandom_range(255)),
                              ($urandom_range(3) == 0));
                end
            end
            k    = $urandom_range(chunk_at.size() - 1);
            pick = $urandom_range(9);
            seg_len = (pick < 8) ? chunk_len[k] : unit;
            flip_at = (pick == 6 || pick == 7) ? $urandom_range(seg_len - 1) : -1;
            seg_end = (s == segs - 1) || whole || (seg_len < unit);
            for (int j = 0; j < seg_len; j++) begin
                if (pick < 8) begin
                    b = base_bytes[chunk_at[k] + j];
                    if (j == flip_at) begin
                        b = b ^ BYTE_W'($urandom_range(1, 255));
                    end
                end else begin
                    b = BYTE_W'($urandom_range(255));
                end
                send_byte(MODE_NEW, b, seg_end && (j == seg_len - 1));
            end
        end
    endtask

    initial begin
        tracker = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        write_chunk_size('0);
        send_byte(MODE_BASE, 8'h00, 1'b0);
        send_byte(MODE_BASE, 8'hFF, 1'b0);
        send_byte(MODE_NEW, 8'hFF, 1'b0);
        send_byte(MODE_NEW, 8'h7E, 1'b1);
        write_chunk_size('1);
        send_byte(MODE_BASE, 8'hA5, 1'b0);
        send_byte(MODE_BASE, 8'h5A, 1'b0);
        send_byte(MODE_BASE, 8'h3C, 1'b1);
        send_byte(MODE_NEW, 8'hA5, 1'b0);
        send_byte(MODE_NEW, 8'h5A, 1'b0);
        send_byte(MODE_NEW, 8'h3C, 1'b1);
        send_byte(MODE_BASE, 8'h11, 1'b0);
        send_byte(MODE_NEW, 8'h22, 1'b1);
        send_byte(MODE_NEW, 8'h33, 1'b0);
        send_byte(MODE_BASE, 8'h44, 1'b1);
        write_chunk_size(17'd8);
        for (int i = 1; i <= 5; i++) begin
            send_byte(MODE_BASE, BYTE_W'(i), 1'b0);
        end
        write_chunk_size(17'd3);
        send_byte(MODE_BASE, 8'h06, 1'b0);
        send_byte(MODE_NEW, 8'h01, 1'b0);
        send_byte(MODE_NEW, 8'h02, 1'b0);
        send_byte(MODE_NEW, 8'h03, 1'b0);

        while (bytes_sent < 550) run_session(pick_chunk_size());
        s_idle_pct = 84;
        m_idle_pct = 25;
        while (bytes_sent < 1000) run_session(pick_chunk_size());
        s_idle_pct = 0;
        m_idle_pct = 0;
        while (bytes_sent < 1300) run_session(pick_chunk_size());

        // fill the table with every one-byte chunk, then push it past full
        write_chunk_size(17'd1);
        for (int i = 0; i < 256; i++) begin
            send_byte(MODE_BASE, BYTE_W'(i), 1'b0);
        end
        write_chunk_size(17'd2);
        repeat (40) send_byte(MODE_BASE, BYTE_W'($urandom_range(255)), 1'b0);
        write_chunk_size(17'd1);
        repeat (30) send_byte(MODE_NEW, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));

        drain();
        $display("Sent %0d bytes; checked %0d commands (%0d copy, %0d insert).",
                 bytes_sent, tracker.checked, tracker.copies, tracker.inserts);
        $display("Chunk sizes 0 to 131071 written; table overflow %s.",
                 tracker.overflowed ? "reached" : "not reached");
        if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
            $display("PASS block_hash_delta_matcher");
        end else begin
            $display("FAIL block_hash_delta_matcher");
        end
        $finish;
    end

endmodule
